/* rtl/core/llm_pkg.sv */
package llm_pkg;

  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgWidth   = 16;

  // Configuration register indexes
  localparam logic CFG_DEADLINE = 1'b0;
  localparam logic CFG_WINDOW   = 1'b1;

  localparam logic [CfgWidth-1:0] WINDOW_RESET = 16'd1000;

  // Item commands
  localparam logic CMD_PASS  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                  window_closed;
    logic [CountWidth-1:0] recent_count;
    logic [CountWidth-1:0] best_count;
    logic [CountWidth-1:0] worst_count;
    logic [TimeWidth-1:0]  worst_gap_ms;
    logic [CountWidth-1:0] missed_count;
  } stats_t;

endpackage

/* rtl/core/llm_stats.sv */
module llm_stats (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            command,
  input  logic [llm_pkg::TimeWidth-1:0]   now_ms,
  input  logic [llm_pkg::CfgWidth-1:0]    deadline_ms,
  input  logic [llm_pkg::CfgWidth-1:0]    window_ms,
  output llm_pkg::stats_t                 result
);
  import llm_pkg::*;

  logic [CountWidth-1:0] pass_count, pass_count_next;
  logic [CountWidth-1:0] recent_passes, recent_passes_next;
  logic [CountWidth-1:0] best_passes, best_passes_next;
  logic [CountWidth-1:0] worst_passes, worst_passes_next;
  logic [TimeWidth-1:0]  largest_gap, largest_gap_next;
  logic [CountWidth-1:0] misses, misses_next;
  logic [TimeWidth-1:0]  last_pass_time, last_pass_time_next;
  logic [TimeWidth-1:0]  window_start_time, window_start_time_next;

  logic [TimeWidth-1:0]  gap;
  logic [TimeWidth-1:0]  elapsed;
  logic [CountWidth-1:0] pass_inc;
  logic                  closing;

  assign gap      = now_ms - last_pass_time;
  assign elapsed  = now_ms - window_start_time;
  assign pass_inc = pass_count + CountWidth'(1);
  assign closing  = elapsed > TimeWidth'(window_ms);

  always_comb begin
    pass_count_next        = pass_count;
    recent_passes_next     = recent_passes;
    best_passes_next       = best_passes;
    worst_passes_next      = worst_passes;
    largest_gap_next       = largest_gap;
    misses_next            = misses;
    last_pass_time_next    = last_pass_time;
    window_start_time_next = window_start_time;
    result.window_closed   = 1'b0;
    if (command == CMD_CLEAR) begin
      pass_count_next        = '0;
      recent_passes_next     = '0;
      best_passes_next       = '0;
      worst_passes_next      = '1;
      misses_next            = '0;
      last_pass_time_next    = now_ms;
      window_start_time_next = now_ms;
    end else begin
      pass_count_next     = pass_inc;
      last_pass_time_next = now_ms;
      if (gap > largest_gap) begin
        largest_gap_next = gap;
      end
      // saturate the miss counter
      if ((deadline_ms != '0) && (gap > TimeWidth'(deadline_ms)) && (misses != '1)) begin
        misses_next = misses + CountWidth'(1);
      end
      if (closing) begin
        recent_passes_next     = pass_inc;
        pass_count_next        = '0;
        window_start_time_next = now_ms;
        result.window_closed   = 1'b1;
        if (pass_inc > best_passes) begin
          best_passes_next = pass_inc;
        end
        if (pass_inc < worst_passes) begin
          worst_passes_next = pass_inc;
        end
      end
    end
    result.recent_count = recent_passes_next;
    result.best_count   = best_passes_next;
    result.worst_count  = worst_passes_next;
    result.worst_gap_ms = largest_gap_next;
    result.missed_count = misses_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count        <= '0;
      recent_passes     <= '0;
      best_passes       <= '0;
      worst_passes      <= '1;
      largest_gap       <= '0;
      misses            <= '0;
      last_pass_time    <= '0;
      window_start_time <= '0;
    end else if (step) begin
      pass_count        <= pass_count_next;
      recent_passes     <= recent_passes_next;
      best_passes       <= best_passes_next;
      worst_passes      <= worst_passes_next;
      largest_gap       <= largest_gap_next;
      misses            <= misses_next;
      last_pass_time    <= last_pass_time_next;
      window_start_time <= window_start_time_next;
    end
  end

endmodule

/* rtl/core/loop_load_monitor.sv */
// Loop load monitor: each item is a loop pass (command 0) or a clear (command 1)
// stamped with a free-running millisecond time. One result item comes out per
// input item and reports the statistics after that item is applied. The block
// takes one item per clock unless out_ready holds it back: an input register
// feeds a single pass of subtract, compare and counter logic that loads the
// statistics and the result register together, and the item shows at
// out_valid. in_ready drops only while both the input register and
// the result register are full and out_ready is low. Configuration writes
// (index 0 deadline_ms, index 1 window_ms) take effect at once and do not clear
// the statistics; issue a clear item afterwards for a fresh start.
module loop_load_monitor (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] now_ms,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        window_closed,
  output logic [31:0] recent_count,
  output logic [31:0] best_count,
  output logic [31:0] worst_count,
  output logic [31:0] worst_gap_ms,
  output logic [31:0] missed_count
);
  import llm_pkg::*;

  logic [CfgWidth-1:0]  deadline_ms;
  logic [CfgWidth-1:0]  window_ms;

  // input register
  logic                 in_q_valid;
  logic                 in_q_command;
  logic [TimeWidth-1:0] in_q_now;

  stats_t               step_result;
  stats_t               out_q;
  logic                 advance;

  // move the held item on when the result register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_ms <= '0;
      window_ms   <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEADLINE: deadline_ms <= cfg_data;
        CFG_WINDOW:   window_ms   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // hold the accepted item until the statistics stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_command <= command;
      in_q_now     <= now_ms;
    end
  end

  llm_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .step        (in_q_valid && advance),
    .command     (in_q_command),
    .now_ms      (in_q_now),
    .deadline_ms (deadline_ms),
    .window_ms   (window_ms),
    .result      (step_result)
  );

  // result register: load with the statistics after the item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_valid) begin
      out_q <= step_result;
    end
  end

  assign window_closed = out_q.window_closed;
  assign recent_count  = out_q.recent_count;
  assign best_count    = out_q.best_count;
  assign worst_count   = out_q.worst_count;
  assign worst_gap_ms  = out_q.worst_gap_ms;
  assign missed_count  = out_q.missed_count;

endmodule

/* rtl/core/llm_checker.sv */
module llm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        window_closed,
  input logic [31:0] recent_count,
  input logic [31:0] best_count,
  input logic [31:0] worst_count,
  input logic [31:0] worst_gap_ms,
  input logic [31:0] missed_count
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(recent_count) && $stable(best_count)
      && $stable(worst_count) && $stable(worst_gap_ms) && $stable(missed_count))
    else $error("stalled result item changed");

  // an empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a closing window lies between worst and best
  a_close_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_closed |-> worst_count <= recent_count && recent_count <= best_count)
    else $error("closed window outside best and worst");

  a_worst_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && worst_count != 32'hFFFF_FFFF |-> worst_count <= best_count)
    else $error("worst count above best count");

endmodule

bind loop_load_monitor llm_checker u_llm_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import llm_pkg::*;

  // One queued input item: a command and its millisecond stamp
  typedef struct {
    logic        cmd;
    logic [31:0] stamp;
  } pass_item_t;

  localparam int unsigned CycleLimit = 200000;

  logic        clk;
  logic        rst = 1'b1;

  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_DEADLINE;
  logic [15:0] cfg_data  = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_PASS;
  logic [31:0] now_ms  = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        window_closed;
  logic [31:0] recent_count;
  logic [31:0] best_count;
  logic [31:0] worst_count;
  logic [31:0] worst_gap_ms;
  logic [31:0] missed_count;

  loop_load_monitor u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_closed(window_closed),
    .recent_count (recent_count),
    .best_count   (best_count),
    .worst_count  (worst_count),
    .worst_gap_ms (worst_gap_ms),
    .missed_count (missed_count)
  );

  // Items waiting to be sent, and statistics the block owes us, oldest first
  pass_item_t pending_items[$];
  stats_t     expected_stats[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait   = 0;
  int unsigned recv_wait   = 0;
  int unsigned stall_draw;
  logic        calm = 1'b0;     // when set, neither side idles
  pass_item_t  next_item;
  logic [31:0] cur_t;           // running time used to build pass sequences

  // Our own copy of the registers and the statistics state
  logic [15:0] deadline_cfg   = 16'd0;
  logic [15:0] window_cfg     = WINDOW_RESET;
  logic [31:0] pass_cnt       = '0;
  logic [31:0] recent_cnt     = '0;
  logic [31:0] best_cnt       = '0;
  logic [31:0] worst_cnt      = '1;
  logic [31:0] max_gap        = '0;
  logic [31:0] miss_cnt       = '0;
  logic [31:0] last_pass_t    = '0;
  logic [31:0] win_start_t    = '0;

  // Apply one item to the statistics and return what the block should report
  function automatic stats_t predict_stats(logic cmd, logic [31:0] t);
    logic [31:0] gap;
    logic [31:0] elapsed;
    stats_t      r;
    r.window_closed = 1'b0;
    if (cmd == CMD_CLEAR) begin
      // A clear keeps the largest gap but restarts everything else at now
      pass_cnt    = '0;
      recent_cnt  = '0;
      best_cnt    = '0;
      worst_cnt   = '1;
      miss_cnt    = '0;
      last_pass_t = t;
      win_start_t = t;
    end else begin
      gap      = t - last_pass_t;
      pass_cnt = pass_cnt + 32'd1;
      if (gap > max_gap) max_gap = gap;
      // Misses saturate rather than wrap
      if (deadline_cfg != 16'd0 && gap > {16'd0, deadline_cfg} && miss_cnt != '1)
        miss_cnt = miss_cnt + 32'd1;
      elapsed = t - win_start_t;
      if (elapsed > {16'd0, window_cfg}) begin
        recent_cnt = pass_cnt;
        pass_cnt   = '0;
        if (recent_cnt > best_cnt) best_cnt = recent_cnt;
        if (recent_cnt < worst_cnt) worst_cnt = recent_cnt;
        win_start_t     = t;
        r.window_closed = 1'b1;
      end
      last_pass_t = t;
    end
    r.recent_count = recent_cnt;
    r.best_count   = best_cnt;
    r.worst_count  = worst_cnt;
    r.worst_gap_ms = max_gap;
    r.missed_count = miss_cnt;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: present queued items, holding each until it is taken, with a
  // random pause before the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      command   <= CMD_PASS;
      now_ms    <= '0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_stats.push_back(predict_stats(command, now_ms));
      // Only move on once the current item has gone
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid  <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          command   <= next_item.cmd;
          now_ms    <= next_item.stamp;
          send_wait <= calm ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results, compare each field with the oldest expectation,
  // then stall the next one for a random wait
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing expected: closed=%0d recent=%h best=%h",
                     $realtime, window_closed, recent_count, best_count);
        end else begin
          automatic stats_t exp_s = expected_stats.pop_front();
          if (exp_s.window_closed !== window_closed || exp_s.recent_count !== recent_count ||
              exp_s.best_count !== best_count || exp_s.worst_count !== worst_count ||
              exp_s.worst_gap_ms !== worst_gap_ms || exp_s.missed_count !== missed_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] expected closed=%0d recent=%h best=%h worst=%h gap=%h miss=%h",
                       $realtime, exp_s.window_closed, exp_s.recent_count, exp_s.best_count,
                       exp_s.worst_count, exp_s.worst_gap_ms, exp_s.missed_count);
              $display("[%0t] actual   closed=%0d recent=%h best=%h worst=%h gap=%h miss=%h",
                       $realtime, window_closed, recent_count, best_count,
                       worst_count, worst_gap_ms, missed_count);
            end
          end
        end
        stall_draw = calm ? 0 : $urandom_range(0, 4);
        recv_wait <= stall_draw;
        out_ready <= (stall_draw == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_item(logic cmd, logic [31:0] stamp);
    pending_items.push_back('{cmd, stamp});
  endtask

  // Hold until the sender is empty and every expected result has arrived
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register; the block is idle whenever this is called
  task automatic set_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEADLINE) deadline_cfg = val;
    else window_cfg = val;
  endtask

  // Mostly well-formed pass sequences with gaps scaled to the window or the
  // deadline; a few clears and a few passes at a random time as noise
  task automatic queue_random(int count);
    int unsigned pick;
    logic [31:0] span;
    @(negedge clk);
    add_item(CMD_CLEAR, cur_t);
    for (int k = 1; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_item(CMD_CLEAR, cur_t);
      end else if (pick < 10) begin
        cur_t = $urandom();
        add_item(CMD_PASS, cur_t);
      end else begin
        if (pick < 70) span = (32'(window_cfg) >> 2) + 32'd3;
        else if (pick < 90) span = 32'(window_cfg) * 2 + 32'd2;
        else span = 32'(deadline_cfg) * 2 + 32'd2;
        cur_t = cur_t + $urandom_range(0, span);
        add_item(CMD_PASS, cur_t);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: window edge at exactly 1000 ms, then one past it,
    // a clear, and gaps that wrap through zero
    @(negedge clk);
    add_item(CMD_PASS, 32'd0);
    add_item(CMD_PASS, 32'd1000);
    add_item(CMD_PASS, 32'd1001);
    add_item(CMD_CLEAR, 32'd5000);
    add_item(CMD_PASS, 32'd5000);
    add_item(CMD_PASS, 32'hFFFF_FFF0);
    add_item(CMD_PASS, 32'h0000_0010);
    add_item(CMD_CLEAR, 32'hFFFF_FFFF);
    add_item(CMD_PASS, 32'd0);
    add_item(CMD_PASS, 32'h8000_0000);
    wait_idle();

    // Largest deadline and window: a gap equal to either is not a miss or a close
    set_reg(CFG_DEADLINE, 16'hFFFF);
    set_reg(CFG_WINDOW, 16'hFFFF);
    @(negedge clk);
    add_item(CMD_CLEAR, 32'd100);
    add_item(CMD_PASS, 32'd100 + 32'd65535);
    add_item(CMD_PASS, 32'd100 + 32'd65536);
    add_item(CMD_PASS, 32'd100 + 32'd131072);
    wait_idle();

    // Zero window closes on any elapsed time; smallest nonzero deadline
    set_reg(CFG_DEADLINE, 16'd1);
    set_reg(CFG_WINDOW, 16'd0);
    @(negedge clk);
    add_item(CMD_CLEAR, 32'd7);
    add_item(CMD_PASS, 32'd7);
    add_item(CMD_PASS, 32'd8);
    add_item(CMD_PASS, 32'd10);
    add_item(CMD_CLEAR, 32'd10);
    wait_idle();

    // Random phases, one per setting; each boundary drains the block
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin set_reg(CFG_DEADLINE, 16'd0);     set_reg(CFG_WINDOW, 16'd1000);  end
        1: begin set_reg(CFG_DEADLINE, 16'd50);    set_reg(CFG_WINDOW, 16'd200);   end
        2: begin set_reg(CFG_DEADLINE, 16'd1);     set_reg(CFG_WINDOW, 16'd1);     end
        3: begin set_reg(CFG_DEADLINE, 16'hFFFF);  set_reg(CFG_WINDOW, 16'hFFFF);  end
        4: begin set_reg(CFG_DEADLINE, 16'($urandom())); set_reg(CFG_WINDOW, 16'($urandom()));
           end
        5: begin set_reg(CFG_DEADLINE, 16'd3);     set_reg(CFG_WINDOW, 16'd0);     end
        6: begin
             set_reg(CFG_DEADLINE, 16'($urandom_range(0, 100)));
             set_reg(CFG_WINDOW, 16'($urandom_range(1, 100)));
           end
        default: begin set_reg(CFG_DEADLINE, 16'd0); set_reg(CFG_WINDOW, 16'hFFFF); end
      endcase
      // Run one phase with no idling at all, and start one just short of the wrap
      calm  = (ph == 2);
      cur_t = (ph == 5) ? 32'hFFFF_FF00 : $urandom();
      queue_random(163);
      wait_idle();
    end
    calm = 1'b0;

    // Drain: give late results a bounded chance, then count any left owing
    repeat (20) @(posedge clk);
    mismatches += expected_stats.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/llm_pkg.sv
rtl/core/llm_stats.sv
rtl/core/loop_load_monitor.sv
rtl/core/llm_checker.sv
dv/tb_top.sv
